### rtl/min_heap_delete_min_unit_assert.svh
// ---------------------------------------------------------------------------
// min_heap_delete_min_unit_assert.svh
// Assertion macros used by the heap engine checker.
// ---------------------------------------------------------------------------
`ifndef MIN_HEAP_DELETE_MIN_UNIT_ASSERT_SVH
`define MIN_HEAP_DELETE_MIN_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define MHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define MHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mhd_pkg.sv
// ---------------------------------------------------------------------------
// mhd_pkg
// Shared constants, codes and types of the min-heap delete-min engine.
// ---------------------------------------------------------------------------
package mhd_pkg;

    // Heap geometry
    localparam int HEAP_DEPTH = 16;
    localparam int ADDR_W     = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CIDX_W     = ADDR_W + 2;
    localparam int VAL_W      = 32;
    localparam int OUT_CNT_W  = 5;
    localparam int ERR_W      = 2;
    localparam int M_DATA_W   = 40;

    // Operation codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    // Result of one operation
    typedef struct packed {
        logic [VAL_W-1:0]     removed_value;
        logic [OUT_CNT_W-1:0] count_after;
        logic [ERR_W-1:0]     error_code;
    } res_t;

    // Heap store access request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_req_t;

    // Entry count as reported on the result channel, modulo 32
    function automatic logic [OUT_CNT_W-1:0] count5(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

### rtl/mhd_ram.sv
// ---------------------------------------------------------------------------
// mhd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module mhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                        rdata_a,
    output logic [WIDTH-1:0]                        rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/mhd_engine.sv
// ---------------------------------------------------------------------------
// mhd_engine
// Operation sequencer: append, root fetch and level-by-level sift-down
// over the heap store.
// ---------------------------------------------------------------------------
module mhd_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     op,
    input  logic [mhd_pkg::VAL_W-1:0] value,
    output mhd_pkg::ram_req_t        ram_req,
    input  logic [mhd_pkg::VAL_W-1:0] rd_a,
    input  logic [mhd_pkg::VAL_W-1:0] rd_b,
    output logic                     res_valid,
    input  logic                     res_ready,
    output mhd_pkg::res_t            res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [mhd_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [mhd_pkg::CNT_W-1:0]         size_reg, size_next;
    logic [mhd_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic [mhd_pkg::VAL_W-1:0]         move_reg, move_next;
    mhd_pkg::res_t                     res_reg, res_next;

    logic [mhd_pkg::CIDX_W-1:0]        left_idx;
    logic [mhd_pkg::CIDX_W-1:0]        right_idx;
    logic [mhd_pkg::CIDX_W-1:0]        child_idx;
    logic                              has_left;
    logic                              has_right;
    logic                              pick_right;
    logic [mhd_pkg::VAL_W-1:0]         child_val;
    logic                              stop;
    logic [mhd_pkg::CNT_W-1:0]         count_inc;
    logic [mhd_pkg::CNT_W-1:0]         count_dec;

    // Children of the current slot and the sift decision
    always_comb begin
        left_idx   = {1'b0, pos_reg, 1'b1};
        right_idx  = left_idx + mhd_pkg::CIDX_W'(1);
        has_left   = left_idx < mhd_pkg::CIDX_W'(size_reg);
        has_right  = right_idx < mhd_pkg::CIDX_W'(size_reg);
        pick_right = has_right && ($signed(rd_b) < $signed(rd_a));
        child_val  = pick_right ? rd_b : rd_a;
        child_idx  = pick_right ? right_idx : left_idx;
        stop       = !has_left || ($signed(move_reg) <= $signed(child_val));
        count_inc  = count_reg + mhd_pkg::CNT_W'(1);
        count_dec  = count_reg - mhd_pkg::CNT_W'(1);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        size_next  = size_reg;
        pos_next   = pos_reg;
        move_next  = move_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;

        ram_req.we      = 1'b0;
        ram_req.waddr   = pos_reg;
        ram_req.wdata   = move_reg;
        ram_req.raddr_a = left_idx[mhd_pkg::ADDR_W-1:0];
        ram_req.raddr_b = right_idx[mhd_pkg::ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    pos_next               = '0;
                    res_next.removed_value = '0;
                    res_next.error_code    = mhd_pkg::ERR_OK;
                    res_next.count_after   = mhd_pkg::count5(count_reg);
                    state_next             = ST_EMIT;
                    if (op == mhd_pkg::OP_APPEND) begin
                        if (count_reg == mhd_pkg::CNT_W'(mhd_pkg::HEAP_DEPTH)) begin
                            res_next.error_code = mhd_pkg::ERR_FULL;
                        end else begin
                            ram_req.we           = 1'b1;
                            ram_req.waddr        = count_reg[mhd_pkg::ADDR_W-1:0];
                            ram_req.wdata        = value;
                            count_next           = count_inc;
                            res_next.count_after = mhd_pkg::count5(count_inc);
                        end
                    end else if (count_reg == '0) begin
                        res_next.error_code = mhd_pkg::ERR_EMPTY;
                    end else begin
                        // fetch root and last entry
                        ram_req.raddr_a      = '0;
                        ram_req.raddr_b      = count_dec[mhd_pkg::ADDR_W-1:0];
                        count_next           = count_dec;
                        size_next            = count_dec;
                        res_next.count_after = mhd_pkg::count5(count_dec);
                        state_next           = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                // capture root and the entry that moves down; reads of
                // the root's children go out now
                res_next.removed_value = rd_a;
                move_next              = rd_b;
                state_next             = ST_CMP;
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                ram_req.we = 1'b1;
                if (stop) begin
                    state_next = ST_EMIT;
                end else begin
                    ram_req.wdata = child_val;
                    pos_next      = child_idx[mhd_pkg::ADDR_W-1:0];
                    state_next    = ST_READ;
                end
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        size_reg <= size_next;
        pos_reg  <= pos_next;
        move_reg <= move_next;
        res_reg  <= res_next;
    end

endmodule

### rtl/mhd_out.sv
// ---------------------------------------------------------------------------
// mhd_out
// Result register stage: packs a result and holds it until its transfer.
// ---------------------------------------------------------------------------
module mhd_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         res_valid,
    output logic                         res_ready,
    input  mhd_pkg::res_t                res,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mhd_pkg::M_DATA_W-1:0] m_tdata
);

    logic                         valid_reg, valid_next;
    logic [mhd_pkg::M_DATA_W-1:0] data_reg, data_next;

    // Load when empty or when the held result transfers this cycle
    always_comb begin
        res_ready  = !valid_reg || m_tready;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready) begin
            valid_next = res_valid;
            if (res_valid) begin
                data_next = {1'b0, res.error_code, res.count_after, res.removed_value};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

### rtl/min_heap_delete_min_unit.sv
// ---------------------------------------------------------------------------
// min_heap_delete_min_unit
// Binary min-heap with append and delete-min over a RAM with registered reads.
// ---------------------------------------------------------------------------
// One operation is in progress at a time; a finished result waits in the
// output register while the next operation is taken. A delete reads the root
// and the last entry, then for each level that the moved entry sinks reads
// both children from the dual-read heap RAM and then compares and writes
// back. With 16 entries the moved entry sinks at most 3 levels. Slots at or
// above the entry count are never read as data.
// ---------------------------------------------------------------------------
module min_heap_delete_min_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [mhd_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value
    input  logic [0:0]                   s_tuser,   // [0] opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] removed_value, [36:32] count_after, [38:37] error_code, [39] zero
    output logic [mhd_pkg::M_DATA_W-1:0] m_tdata
);

    mhd_pkg::ram_req_t          ram_req;
    logic [mhd_pkg::VAL_W-1:0]  rd_a;
    logic [mhd_pkg::VAL_W-1:0]  rd_b;
    logic                       res_valid;
    logic                       res_ready;
    mhd_pkg::res_t              res;

    // Heap store
    mhd_ram #(
        .WIDTH (mhd_pkg::VAL_W),
        .DEPTH (mhd_pkg::HEAP_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Operation sequencer
    mhd_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .op        (s_tuser[0]),
        .value     (s_tdata),
        .ram_req   (ram_req),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Result register
    mhd_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### rtl/mhd_checker.sv
// ---------------------------------------------------------------------------
// mhd_checker
// Port-level checks of the min-heap engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "min_heap_delete_min_unit_assert.svh"

module mhd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mhd_pkg::M_DATA_W-1:0] m_tdata
);

    logic [mhd_pkg::VAL_W-1:0]     chk_removed;
    logic [mhd_pkg::OUT_CNT_W-1:0] chk_count;
    logic [mhd_pkg::ERR_W-1:0]     chk_err;
    logic [mhd_pkg::OUT_CNT_W-1:0] chk_full;

    assign chk_removed = m_tdata[31:0];
    assign chk_count   = m_tdata[36:32];
    assign chk_err     = m_tdata[38:37];
    assign chk_full    = mhd_pkg::count5(mhd_pkg::CNT_W'(mhd_pkg::HEAP_DEPTH));

    // Held result stays put until its transfer
    `MHD_ASSERT_NEXT(a_hold_result, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Only defined error codes appear
    `MHD_ASSERT_NOW(a_err_code, m_tvalid, chk_err == mhd_pkg::ERR_OK || chk_err == mhd_pkg::ERR_EMPTY || chk_err == mhd_pkg::ERR_FULL, "undefined error code")

    // A delete on empty reports an empty heap and no value
    `MHD_ASSERT_NOW(a_empty, m_tvalid && chk_err == mhd_pkg::ERR_EMPTY, chk_count == '0 && chk_removed == '0, "bad delete-on-empty result")

    // An append on full reports a full heap and no value
    `MHD_ASSERT_NOW(a_full, m_tvalid && chk_err == mhd_pkg::ERR_FULL, chk_count == chk_full && chk_removed == '0, "bad append-on-full result")

endmodule

bind min_heap_delete_min_unit mhd_checker u_mhd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/min_heap_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// min_heap_result_checker
// Passive checker for the min-heap delete-min engine: it mirrors the heap
// from every accepted input transfer, queues the predicted result, and
// compares each accepted output transfer field by field in order.
// ---------------------------------------------------------------------------
module min_heap_result_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [mhd_pkg::VAL_W-1:0]    s_tdata,   // [31:0] value
    input  logic [0:0]                   s_tuser,   // [0] opcode
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] removed_value, [36:32] count_after, [38:37] error_code, [39] zero
    input  logic [mhd_pkg::M_DATA_W-1:0] m_tdata,
    output int                           mismatch_count,
    output int                           results_pending
);

    // Cap on printed mismatch lines so a broken design cannot flood the log
    localparam int REPORT_CAP = 200;

    // Mirror of the heap store and its fill level
    logic signed [mhd_pkg::VAL_W-1:0] heap_mirror [mhd_pkg::HEAP_DEPTH];
    int                               mirror_count;
    mhd_pkg::res_t                    expected_results [$];
    int                               lines_reported;

    // Apply one operation to the mirror and return the result it produces
    function automatic mhd_pkg::res_t apply_heap_op(input logic op,
                                                    input logic signed [31:0] value);
        mhd_pkg::res_t     r;
        int                pos;
        int                pick;
        logic              sinking;
        logic signed [31:0] tmp;
        r.removed_value = '0;
        r.error_code    = mhd_pkg::ERR_OK;
        if (op == mhd_pkg::OP_APPEND) begin
            if (mirror_count >= mhd_pkg::HEAP_DEPTH) begin
                r.error_code = mhd_pkg::ERR_FULL;
            end else begin
                heap_mirror[mirror_count] = value;
                mirror_count++;
            end
        end else if (mirror_count == 0) begin
            r.error_code = mhd_pkg::ERR_EMPTY;
        end else begin
            r.removed_value = heap_mirror[0];
            mirror_count--;
            heap_mirror[0] = heap_mirror[mirror_count];
            // Sift down toward the smaller child, left one on a tie
            pos     = 0;
            sinking = 1'b1;
            while (sinking && (2 * pos + 1 < mirror_count)) begin
                pick = 2 * pos + 1;
                if (pick + 1 < mirror_count && heap_mirror[pick] > heap_mirror[pick + 1])
                    pick = pick + 1;
                if (heap_mirror[pos] <= heap_mirror[pick]) begin
                    sinking = 1'b0;
                end else begin
                    tmp               = heap_mirror[pos];
                    heap_mirror[pos]  = heap_mirror[pick];
                    heap_mirror[pick] = tmp;
                    pos               = pick;
                end
            end
        end
        r.count_after = mirror_count[mhd_pkg::OUT_CNT_W-1:0];
        return r;
    endfunction

    // Predict on input transfers, compare on output transfers
    always @(posedge aclk) begin : watch_channels
        mhd_pkg::res_t want;
        mhd_pkg::res_t got;
        int            errs;
        errs = 0;
        if (!aresetn) begin
            mirror_count = 0;
            expected_results.delete();
            lines_reported = 0;
            mismatch_count  <= 0;
            results_pending <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_heap_op(s_tuser[0], $signed(s_tdata)));
            if (m_tvalid && m_tready) begin
                got.removed_value = m_tdata[31:0];
                got.count_after   = m_tdata[36:32];
                got.error_code    = m_tdata[38:37];
                if (expected_results.size() == 0) begin
                    errs++;
                    if (lines_reported < REPORT_CAP)
                        $display("%0t: unexpected result: expected none, actual %h",
                                 $time, m_tdata);
                    lines_reported++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.removed_value !== want.removed_value) begin
                        errs++;
                        if (lines_reported < REPORT_CAP)
                            $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                                     $time, $signed(want.removed_value),
                                     $signed(got.removed_value));
                        lines_reported++;
                    end
                    if (got.count_after !== want.count_after) begin
                        errs++;
                        if (lines_reported < REPORT_CAP)
                            $display("%0t: count_after mismatch: expected %0d, actual %0d",
                                     $time, want.count_after, got.count_after);
                        lines_reported++;
                    end
                    if (got.error_code !== want.error_code) begin
                        errs++;
                        if (lines_reported < REPORT_CAP)
                            $display("%0t: error_code mismatch: expected %0d, actual %0d",
                                     $time, want.error_code, got.error_code);
                        lines_reported++;
                    end
                end
            end
            mismatch_count  <= mismatch_count + errs;
            results_pending <= expected_results.size();
        end
    end

endmodule

### verif/tb_min_heap_delete_min_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_min_heap_delete_min_unit
// Stimulus and verdict for the min-heap delete-min engine. A directed burst
// fills, overfills and partly drains the heap with extreme values, then random
// traffic mixes heap-ordered loads with drains, unordered loads and stray
// operations under three sender/receiver stall profiles.
// ---------------------------------------------------------------------------
module tb_min_heap_delete_min_unit;

    localparam int OPS_PER_PHASE = 500;
    localparam int SIGNED_MAX    = 32'h7FFF_FFFF;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mhd_pkg::VAL_W-1:0]    s_tdata;   // [31:0] value
    logic [0:0]                   s_tuser;   // [0] opcode
    logic                         m_tvalid;
    logic                         m_tready;
    // [31:0] removed_value, [36:32] count_after, [38:37] error_code, [39] zero
    logic [mhd_pkg::M_DATA_W-1:0] m_tdata;

    int          mismatch_count;
    int          results_pending;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          heap_level;
    int          ops_sent;
    logic [31:0] directed_load [16];

    min_heap_delete_min_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    min_heap_result_checker u_result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Receiver: stall at random per the current profile
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    // Hang guard
    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

    // Value mix biased toward the signed extremes and small numbers
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'($signed($urandom_range(0, 8)) - 4);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one operation, with an optional idle gap first; hold until transfer
    task automatic push_op(input logic op, input logic [31:0] value);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == mhd_pkg::OP_APPEND && heap_level < mhd_pkg::HEAP_DEPTH)
            heap_level++;
        else if (op == mhd_pkg::OP_DELETE && heap_level > 0)
            heap_level--;
        ops_sent++;
    endtask

    // Stop offering and hold until every predicted result has drained
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Random traffic, mostly heap-ordered load-then-drain sequences
    task automatic run_random(input int target);
        int     n;
        longint cur;
        longint step;
        while (ops_sent < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    while (heap_level > 0) push_op(mhd_pkg::OP_DELETE, pick_value());
                    n   = $urandom_range(1, mhd_pkg::HEAP_DEPTH);
                    cur = longint'($signed(pick_value()));
                    // Ascending loads are valid heaps
                    repeat (n) begin
                        push_op(mhd_pkg::OP_APPEND, cur[31:0]);
                        case ($urandom_range(0, 3))
                            0:       step = 0;
                            1:       step = $urandom_range(1, 16);
                            default: step = longint'($urandom >> $urandom_range(1, 31));
                        endcase
                        cur = (cur + step > SIGNED_MAX) ? SIGNED_MAX : cur + step;
                    end
                    repeat ($urandom_range(1, n + 2)) push_op(mhd_pkg::OP_DELETE, pick_value());
                end
                6, 7: begin
                    repeat ($urandom_range(1, 8)) push_op(mhd_pkg::OP_APPEND, pick_value());
                end
                default: begin
                    push_op(1'($urandom_range(0, 1)), pick_value());
                end
            endcase
        end
    endtask

    initial begin
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = mhd_pkg::OP_APPEND;
        heap_level        = 0;
        ops_sent          = 0;
        sender_idle_pct   = 12;
        receiver_idle_pct = 71;
        directed_load = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF,
                          32'd100,       32'hFFFF_FF9C, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'd7,         32'd7,         32'd3,         32'h0000_FFFF};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: delete on empty, unordered fill with extremes,
        // append on full, then partial drain
        push_op(mhd_pkg::OP_DELETE, 32'hFFFF_FFFF);
        foreach (directed_load[k]) push_op(mhd_pkg::OP_APPEND, directed_load[k]);
        push_op(mhd_pkg::OP_APPEND, 32'h1234_5678);
        repeat (7) push_op(mhd_pkg::OP_DELETE, pick_value());

        // Three stall profiles, draining fully between them
        run_random(OPS_PER_PHASE);
        wait_drained();
        sender_idle_pct   = 71;
        receiver_idle_pct = 12;
        run_random(2 * OPS_PER_PHASE);
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(3 * OPS_PER_PHASE);
        wait_drained();
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
